[rtl/clnc_pkg.sv]
// ----------------------------------------------------------------------------
// clnc_pkg
// Types and constants shared by the cell list neighbour count block.
// ----------------------------------------------------------------------------
package clnc_pkg;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 24;
  localparam int CNT_W   = 10;
  localparam int LINK_W  = IDX_W + 1;
  localparam int BOX_W   = 5;
  localparam int CELL_W  = 2 * BOX_W;
  localparam int N_PART  = 1 << IDX_W;
  localparam int N_CELLS = 1 << CELL_W;

  // empty marker for heads and links
  localparam logic [LINK_W-1:0] NO_PART  = LINK_W'(N_PART);
  localparam logic [5:0]        MAX_BOX  = 6'd32;
  localparam logic [5:0]        MIN_BOX  = 6'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [2:0] REG_BOX_SIZE  = 3'd0;
  localparam logic [2:0] REG_RADIUS_SQ = 3'd1;
  localparam logic [2:0] REG_LENGTH_X  = 3'd2;
  localparam logic [2:0] REG_LENGTH_Y  = 3'd3;
  localparam logic [2:0] REG_BOXES_X   = 3'd4;
  localparam logic [2:0] REG_BOXES_Y   = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_UNPLACED = 2'd2
  } clnc_status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PL_DIV,
    ST_PL_DEC,
    ST_UL_RD,
    ST_UL_WR,
    ST_PS_RD,
    ST_PS_WR,
    ST_PS_FIX,
    ST_Q_START,
    ST_Q_CELL,
    ST_Q_HEAD,
    ST_Q_RD,
    ST_Q_DAT,
    ST_Q_SQ,
    ST_Q_ACC,
    ST_DONE
  } clnc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cdiv_stat_t;

endpackage

[rtl/clnc_in_if.sv]
// ----------------------------------------------------------------------------
// clnc_in_if
// Request channel: mode, particle index and new position.
// ----------------------------------------------------------------------------
interface clnc_in_if import clnc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [IDX_W-1:0]   particle_index;
  logic [COORD_W-1:0] x_position;
  logic [COORD_W-1:0] y_position;

  modport source (output valid, mode, particle_index, x_position, y_position,
                  input ready);
  modport sink   (input valid, mode, particle_index, x_position, y_position,
                  output ready);
endinterface

[rtl/clnc_out_if.sv]
// ----------------------------------------------------------------------------
// clnc_out_if
// Result channel: neighbour count and status.
// ----------------------------------------------------------------------------
interface clnc_out_if import clnc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] neighbour_count;
  logic [1:0]       status;

  modport source (output valid, neighbour_count, status, input ready);
  modport sink   (input valid, neighbour_count, status, output ready);
endinterface

[rtl/cell_list_neighbour_count_top.sv]
// ----------------------------------------------------------------------------
// cell_list_neighbour_count_top
// Periodic 2D cell list with place/move and per-particle neighbour count.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 1024 entries of its cell head and particle
// cell tables before taking its first request; configuration writes are taken
// throughout. One request is in work at a time. A place or move passes through
// the cell coordinate divider and the unlink/push read-modify-write passes on
// the link memories. A query walks the particles in the nine cells visited:
// each visited particle costs one memory read, one difference stage, one
// squaring stage and one compare. The result sits in an output register, so a
// waiting result does not block the next request.
// ----------------------------------------------------------------------------
module cell_list_neighbour_count_top
  import clnc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  clnc_in_if.sink     in_chan,
  clnc_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration
  logic [COORD_W-1:0] box_size_r, length_x_r, length_y_r;
  logic [47:0]        radius_sq_r;
  logic [5:0]         boxes_x_r, boxes_y_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_size_r  <= 24'd4096;
      radius_sq_r <= 48'd16777216;
      length_x_r  <= 24'd131072;
      length_y_r  <= 24'd131072;
      boxes_x_r   <= 6'd32;
      boxes_y_r   <= 6'd32;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BOX_SIZE:  box_size_r  <= pwdata[COORD_W-1:0];
        REG_RADIUS_SQ: radius_sq_r <= pwdata[47:0];
        REG_LENGTH_X:  length_x_r  <= pwdata[COORD_W-1:0];
        REG_LENGTH_Y:  length_y_r  <= pwdata[COORD_W-1:0];
        REG_BOXES_X:   boxes_x_r   <= pwdata[5:0];
        REG_BOXES_Y:   boxes_y_r   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_SIZE:  prdata = 64'(box_size_r);
      REG_RADIUS_SQ: prdata = 64'(radius_sq_r);
      REG_LENGTH_X:  prdata = 64'(length_x_r);
      REG_LENGTH_Y:  prdata = 64'(length_y_r);
      REG_BOXES_X:   prdata = 64'(boxes_x_r);
      REG_BOXES_Y:   prdata = 64'(boxes_y_r);
      default:       prdata = '0;
    endcase
  end

  // grid size in use, held to 3..32
  logic [5:0]       nbx, nby;
  logic [BOX_W-1:0] lastx, lasty;

  assign nbx   = (boxes_x_r < MIN_BOX) ? MIN_BOX : (boxes_x_r > MAX_BOX) ? MAX_BOX : boxes_x_r;
  assign nby   = (boxes_y_r < MIN_BOX) ? MIN_BOX : (boxes_y_r > MAX_BOX) ? MAX_BOX : boxes_y_r;
  assign lastx = BOX_W'(nbx - 6'd1);
  assign lasty = BOX_W'(nby - 6'd1);

  // memories
  logic [LINK_W-1:0]    head_mem [N_CELLS];
  logic [LINK_W-1:0]    next_mem [N_PART];
  logic [LINK_W-1:0]    prev_mem [N_PART];
  logic [2*COORD_W-1:0] pos_mem  [N_PART];
  logic [CELL_W:0]      cell_mem [N_PART];   // {placed, cell}

  logic                 head_we, next_we, prev_we, pos_we, cell_we;
  logic [CELL_W-1:0]    head_wa, head_ra;
  logic [IDX_W-1:0]     next_wa, next_ra, prev_wa, prev_ra;
  logic [IDX_W-1:0]     pos_wa, pos_ra, cell_wa, cell_ra;
  logic [LINK_W-1:0]    head_wd, next_wd, prev_wd;
  logic [2*COORD_W-1:0] pos_wd;
  logic [CELL_W:0]      cell_wd;
  logic [LINK_W-1:0]    head_rd_r, next_rd_r, prev_rd_r;
  logic [2*COORD_W-1:0] pos_rd_r;
  logic [CELL_W:0]      cell_rd_r;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_r <= next_mem[next_ra];
  end
  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_r <= prev_mem[prev_ra];
  end
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_r <= pos_mem[pos_ra];
  end
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rd_r <= cell_mem[cell_ra];
  end

  // control and datapath registers
  clnc_state_t          state_r, state_nxt;
  logic [CELL_W-1:0]    clr_r, clr_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [COORD_W-1:0]   xin_r, xin_nxt, yin_r, yin_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CELL_W-1:0]    oldcell_r, oldcell_nxt, newcell_r, newcell_nxt;
  logic [LINK_W-1:0]    old_r, old_nxt, j_r, j_nxt;
  logic [COORD_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [BOX_W-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic [1:0]           dxi_r, dxi_nxt, dyi_r, dyi_nxt;
  logic signed [25:0]   ex_r, ex_nxt, ey_r, ey_nxt;
  logic [25:0]          adx_r, adx_nxt, ady_r, ady_nxt;
  logic [51:0]          sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic                 skip_r, skip_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [CNT_W-1:0]     ocount_r, ocount_nxt;
  logic [1:0]           ostatus_r, ostatus_nxt;

  logic                 accept, range_bad, last_cell, out_free, dist_hit;
  logic                 placed_rd;
  logic [CELL_W-1:0]    oldcell_rd;
  logic signed [26:0]   ddx, ddy;
  logic [52:0]          d2;
  logic [BOX_W-1:0]     ncx, ncy, cxq, cyq;
  logic signed [25:0]   ex_c, ey_c;
  cdiv_stat_t           divx_stat, divy_stat;
  logic                 div_start;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign range_bad     = (in_chan.x_position >= length_x_r) ||
                         (in_chan.y_position >= length_y_r);
  assign div_start     = accept && !in_chan.mode && !range_bad;
  assign last_cell     = (dxi_r == 2'd2) && (dyi_r == 2'd2);
  assign out_free      = !ovalid_r || out_chan.ready;
  assign placed_rd     = cell_rd_r[CELL_W];
  assign oldcell_rd    = cell_rd_r[CELL_W-1:0];

  clnc_cdiv u_divx (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .pos (in_chan.x_position), .side (box_size_r), .last (lastx),
    .stat (divx_stat), .coord (cxq)
  );
  clnc_cdiv u_divy (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .pos (in_chan.y_position), .side (box_size_r), .last (lasty),
    .stat (divy_stat), .coord (cyq)
  );

  // neighbour cell with periodic wrap and the length offset it carries
  always_comb begin
    ncx  = cx_r;
    ex_c = '0;
    case (dxi_r)
      2'd0: begin
        if (cx_r == '0) begin
          ncx  = lastx;
          ex_c = -$signed({2'b00, length_x_r});
        end else begin
          ncx = cx_r - BOX_W'(1);
        end
      end
      2'd2: begin
        if (cx_r == lastx) begin
          ncx  = '0;
          ex_c = $signed({2'b00, length_x_r});
        end else begin
          ncx = cx_r + BOX_W'(1);
        end
      end
      default: ncx = cx_r;
    endcase
    ncy  = cy_r;
    ey_c = '0;
    case (dyi_r)
      2'd0: begin
        if (cy_r == '0) begin
          ncy  = lasty;
          ey_c = -$signed({2'b00, length_y_r});
        end else begin
          ncy = cy_r - BOX_W'(1);
        end
      end
      2'd2: begin
        if (cy_r == lasty) begin
          ncy  = '0;
          ey_c = $signed({2'b00, length_y_r});
        end else begin
          ncy = cy_r + BOX_W'(1);
        end
      end
      default: ncy = cy_r;
    endcase
  end

  assign ddx = $signed({3'b000, pos_rd_r[2*COORD_W-1:COORD_W]}) + 27'(ex_r)
             - $signed({3'b000, px_r});
  assign ddy = $signed({3'b000, pos_rd_r[COORD_W-1:0]}) + 27'(ey_r)
             - $signed({3'b000, py_r});
  assign d2       = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign dist_hit = d2 < {5'b0, radius_sq_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_chan.mode)   state_nxt = ST_Q_START;
          else if (range_bad) state_nxt = ST_DONE;
          else                state_nxt = ST_PL_DIV;
        end
      end
      ST_PL_DIV:  if (divx_stat.done) state_nxt = ST_PL_DEC;
      ST_PL_DEC: begin
        if (!placed_rd)                  state_nxt = ST_PS_RD;
        else if (oldcell_rd != newcell_r) state_nxt = ST_UL_RD;
        else                             state_nxt = ST_DONE;
      end
      ST_UL_RD:   state_nxt = ST_UL_WR;
      ST_UL_WR:   state_nxt = ST_PS_RD;
      ST_PS_RD:   state_nxt = ST_PS_WR;
      ST_PS_WR:   state_nxt = head_rd_r[IDX_W] ? ST_DONE : ST_PS_FIX;
      ST_PS_FIX:  state_nxt = ST_DONE;
      ST_Q_START: state_nxt = placed_rd ? ST_Q_CELL : ST_DONE;
      ST_Q_CELL:  state_nxt = ST_Q_HEAD;
      ST_Q_HEAD: begin
        if (!head_rd_r[IDX_W]) state_nxt = ST_Q_RD;
        else if (last_cell)    state_nxt = ST_DONE;
        else                   state_nxt = ST_Q_CELL;
      end
      ST_Q_RD:    state_nxt = ST_Q_DAT;
      ST_Q_DAT:   state_nxt = ST_Q_SQ;
      ST_Q_SQ:    state_nxt = ST_Q_ACC;
      ST_Q_ACC: begin
        if (!j_r[IDX_W])    state_nxt = ST_Q_RD;
        else if (last_cell) state_nxt = ST_DONE;
        else                state_nxt = ST_Q_CELL;
      end
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_nxt     = clr_r;
    idx_nxt     = idx_r;
    xin_nxt     = xin_r;
    yin_nxt     = yin_r;
    status_nxt  = status_r;
    count_nxt   = count_r;
    oldcell_nxt = oldcell_r;
    newcell_nxt = newcell_r;
    old_nxt     = old_r;
    j_nxt       = j_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    dxi_nxt     = dxi_r;
    dyi_nxt     = dyi_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    adx_nxt     = adx_r;
    ady_nxt     = ady_r;
    sqx_nxt     = sqx_r;
    sqy_nxt     = sqy_r;
    skip_nxt    = skip_r;
    ovalid_nxt  = ovalid_r && !out_chan.ready;
    ocount_nxt  = ocount_r;
    ostatus_nxt = ostatus_r;

    head_we = 1'b0; head_wa = newcell_r; head_wd = {1'b0, idx_r}; head_ra = newcell_r;
    next_we = 1'b0; next_wa = idx_r;     next_wd = NO_PART;       next_ra = idx_r;
    prev_we = 1'b0; prev_wa = idx_r;     prev_wd = NO_PART;       prev_ra = idx_r;
    pos_we  = 1'b0; pos_wa  = idx_r;     pos_wd  = {xin_r, yin_r}; pos_ra = idx_r;
    cell_we = 1'b0; cell_wa = idx_r;     cell_wd = {1'b1, newcell_r};
    cell_ra = in_chan.ready ? in_chan.particle_index : idx_r;

    case (state_r)
      ST_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        head_wd = NO_PART;
        cell_we = 1'b1;
        cell_wa = clr_r;
        cell_wd = '0;
        clr_nxt = clr_r + CELL_W'(1);
      end
      ST_IDLE: begin
        pos_ra = in_chan.particle_index;
        if (accept) begin
          idx_nxt    = in_chan.particle_index;
          xin_nxt    = in_chan.x_position;
          yin_nxt    = in_chan.y_position;
          count_nxt  = '0;
          status_nxt = (!in_chan.mode && range_bad) ? STATUS_RANGE : STATUS_OK;
        end
      end
      ST_PL_DIV: begin
        if (divx_stat.done) newcell_nxt = {cyq, cxq};
      end
      ST_PL_DEC: begin
        pos_we      = 1'b1;
        oldcell_nxt = oldcell_rd;
      end
      ST_UL_RD: begin
        head_ra = oldcell_r;
      end
      ST_UL_WR: begin
        // head_rd_r: head of the old cell; next/prev_rd_r: links of this particle
        if (head_rd_r == {1'b0, idx_r}) begin
          head_we = 1'b1;
          head_wa = oldcell_r;
          head_wd = next_rd_r;
          prev_we = !next_rd_r[IDX_W];
          prev_wa = next_rd_r[IDX_W-1:0];
          prev_wd = NO_PART;
        end else begin
          next_we = !prev_rd_r[IDX_W];
          next_wa = prev_rd_r[IDX_W-1:0];
          next_wd = next_rd_r;
          prev_we = !next_rd_r[IDX_W];
          prev_wa = next_rd_r[IDX_W-1:0];
          prev_wd = prev_rd_r;
        end
      end
      ST_PS_RD: ;
      ST_PS_WR: begin
        head_we = 1'b1;
        next_we = 1'b1;
        next_wd = head_rd_r;
        prev_we = 1'b1;
        cell_we = 1'b1;
        old_nxt = head_rd_r;
      end
      ST_PS_FIX: begin
        prev_we = 1'b1;
        prev_wa = old_r[IDX_W-1:0];
        prev_wd = {1'b0, idx_r};
      end
      ST_Q_START: begin
        if (!placed_rd) begin
          status_nxt = STATUS_UNPLACED;
        end
        cx_nxt  = (oldcell_rd[BOX_W-1:0] > lastx) ? lastx : oldcell_rd[BOX_W-1:0];
        cy_nxt  = (oldcell_rd[CELL_W-1:BOX_W] > lasty) ? lasty : oldcell_rd[CELL_W-1:BOX_W];
        px_nxt  = pos_rd_r[2*COORD_W-1:COORD_W];
        py_nxt  = pos_rd_r[COORD_W-1:0];
        dxi_nxt = '0;
        dyi_nxt = '0;
      end
      ST_Q_CELL: begin
        head_ra = {ncy, ncx};
        ex_nxt  = ex_c;
        ey_nxt  = ey_c;
      end
      ST_Q_HEAD: begin
        j_nxt = head_rd_r;
        if (head_rd_r[IDX_W] && !last_cell) begin
          if (dxi_r == 2'd2) begin
            dxi_nxt = '0;
            dyi_nxt = dyi_r + 2'd1;
          end else begin
            dxi_nxt = dxi_r + 2'd1;
          end
        end
      end
      ST_Q_RD: begin
        next_ra = j_r[IDX_W-1:0];
        pos_ra  = j_r[IDX_W-1:0];
      end
      ST_Q_DAT: begin
        adx_nxt  = ddx[26] ? 26'(-ddx) : ddx[25:0];
        ady_nxt  = ddy[26] ? 26'(-ddy) : ddy[25:0];
        skip_nxt = (j_r == {1'b0, idx_r});
        j_nxt    = next_rd_r;
      end
      ST_Q_SQ: begin
        sqx_nxt = adx_r * adx_r;
        sqy_nxt = ady_r * ady_r;
      end
      ST_Q_ACC: begin
        if (!skip_r && dist_hit && (count_r != CNT_MAX)) count_nxt = count_r + CNT_W'(1);
        if (j_r[IDX_W] && !last_cell) begin
          if (dxi_r == 2'd2) begin
            dxi_nxt = '0;
            dyi_nxt = dyi_r + 2'd1;
          end else begin
            dxi_nxt = dxi_r + 2'd1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ovalid_nxt  = 1'b1;
          ocount_nxt  = count_r;
          ostatus_nxt = status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    idx_r     <= idx_nxt;
    xin_r     <= xin_nxt;
    yin_r     <= yin_nxt;
    status_r  <= status_nxt;
    count_r   <= count_nxt;
    oldcell_r <= oldcell_nxt;
    newcell_r <= newcell_nxt;
    old_r     <= old_nxt;
    j_r       <= j_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    dxi_r     <= dxi_nxt;
    dyi_r     <= dyi_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    sqx_r     <= sqx_nxt;
    sqy_r     <= sqy_nxt;
    skip_r    <= skip_nxt;
    ocount_r  <= ocount_nxt;
    ostatus_r <= ostatus_nxt;
  end

  assign out_chan.valid           = ovalid_r;
  assign out_chan.neighbour_count = ocount_r;
  assign out_chan.status          = ostatus_r;

`ifndef NO_ASSERTIONS
  // list walk must never disturb the head table
  a_no_head_wr_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_CELL || state_r == ST_Q_HEAD || state_r == ST_Q_RD ||
     state_r == ST_Q_DAT || state_r == ST_Q_SQ || state_r == ST_Q_ACC) |-> !head_we)
    else $error("head table written during query walk");

  a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != STATUS_OK) |-> out_chan.neighbour_count == '0)
    else $error("nonzero count with error status");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("request accepted but block stayed idle");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    divx_stat == divy_stat)
    else $error("cell coordinate units out of step");
`endif

endmodule

[rtl/clnc_cdiv.sv]
// ----------------------------------------------------------------------------
// clnc_cdiv
// Cell coordinate unit: min(pos / side, last), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clnc_cdiv
  import clnc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] pos,
  input  logic [COORD_W-1:0] side,
  input  logic [BOX_W-1:0]   last,
  output cdiv_stat_t         stat,
  output logic [BOX_W-1:0]   coord
);

  localparam int SH_W = COORD_W + BOX_W;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [COORD_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] side_r, side_nxt;
  logic [BOX_W-1:0]   q_r, q_nxt;
  logic [BOX_W-1:0]   last_r, last_nxt;
  logic               sat_r, sat_nxt;
  logic [COORD_W-1:0] side_eff;
  logic [SH_W-1:0]    trial;

  assign side_eff = (side == '0) ? COORD_W'(1) : side;
  assign trial    = {{BOX_W{1'b0}}, side_r} << k_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    side_nxt = side_r;
    q_nxt    = q_r;
    last_nxt = last_r;
    sat_nxt  = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = 3'(BOX_W - 1);
      rem_nxt  = pos;
      side_nxt = side_eff;
      q_nxt    = '0;
      last_nxt = last;
      // quotient of 2^BOX_W or more always clamps
      sat_nxt  = {{BOX_W{1'b0}}, pos} >= {side_eff, {BOX_W{1'b0}}};
    end else if (busy_r) begin
      if ({{BOX_W{1'b0}}, rem_r} >= trial) begin
        rem_nxt        = rem_r - trial[COORD_W-1:0];
        q_nxt[k_r[2:0]] = 1'b1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r    <= k_nxt;
    rem_r  <= rem_nxt;
    side_r <= side_nxt;
    q_r    <= q_nxt;
    last_r <= last_nxt;
    sat_r  <= sat_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign coord     = (sat_r || (q_r > last_r)) ? last_r : q_r;

endmodule

[test/cell_list_neighbour_count_top_test.sv]
// ----------------------------------------------------------------------------
// cell_list_neighbour_count_top_test
// Self-checking bench for the cell list neighbour count block. Places, moves
// and queries particles under several register settings, predicts every
// result with an independent cell list model and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cell_list_neighbour_count_top_test;
  import clnc_pkg::*;

  typedef struct {
    logic [CNT_W-1:0] count;
    clnc_status_t     status;
  } nbr_result_t;

  class nbr_scoreboard;
    bit [23:0]   box_size;
    bit [47:0]   radius_sq;
    bit [23:0]   len_x, len_y;
    bit [5:0]    boxes_x, boxes_y;
    int          head[N_CELLS];
    int          nxt[N_PART];
    int          prv[N_PART];
    int          pos_x[N_PART];
    int          pos_y[N_PART];
    int          cell_of[N_PART];
    bit          placed[N_PART];
    int          placed_ids[$];
    nbr_result_t expected_q[$];
    int          errors;

    function new();
      box_size  = 24'd4096;
      radius_sq = 48'd16777216;
      len_x     = 24'd131072;
      len_y     = 24'd131072;
      boxes_x   = MAX_BOX;
      boxes_y   = MAX_BOX;
      foreach (head[k]) head[k] = N_PART;
      foreach (placed[k]) placed[k] = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, longint unsigned v);
      case (idx)
        REG_BOX_SIZE:  box_size  = v[23:0];
        REG_RADIUS_SQ: radius_sq = v[47:0];
        REG_LENGTH_X:  len_x     = v[23:0];
        REG_LENGTH_Y:  len_y     = v[23:0];
        REG_BOXES_X:   boxes_x   = v[5:0];
        REG_BOXES_Y:   boxes_y   = v[5:0];
        default: ;
      endcase
    endfunction

    function int boxes_in_use(bit [5:0] n);
      if (n < MIN_BOX) return MIN_BOX;
      if (n > MAX_BOX) return MAX_BOX;
      return n;
    endfunction

    function int box_of(int pos, int nboxes);
      int side;
      int c;
      side = (box_size == 0) ? 1 : box_size;
      c = pos / side;
      return (c > nboxes - 1) ? nboxes - 1 : c;
    endfunction

    function void unlink(int p);
      int c;
      int n;
      c = cell_of[p];
      n = nxt[p];
      if (head[c] == p) begin
        head[c] = n;
        if (n < N_PART) prv[n] = N_PART;
      end else begin
        if (prv[p] < N_PART) nxt[prv[p]] = n;
        if (n < N_PART) prv[n] = prv[p];
      end
    endfunction

    function void push(int p, int c);
      int old;
      old = head[c];
      head[c] = p;
      prv[p] = N_PART;
      nxt[p] = old;
      if (old < N_PART) prv[old] = p;
      cell_of[p] = c;
    endfunction

    function int count_near(int p);
      int nbx, nby, cx, cy, ncx, ncy, j, dx, dy, total;
      longint ex, ey, ddx, ddy, d2;
      nbx = boxes_in_use(boxes_x);
      nby = boxes_in_use(boxes_y);
      cx = cell_of[p] % 32;
      cy = cell_of[p] / 32;
      if (cx > nbx - 1) cx = nbx - 1;
      if (cy > nby - 1) cy = nby - 1;
      total = 0;
      for (dy = -1; dy <= 1; dy++) begin
        for (dx = -1; dx <= 1; dx++) begin
          ncx = cx + dx; ncy = cy + dy; ex = 0; ey = 0;
          if (ncx < 0) begin ncx = nbx - 1; ex = -longint'(len_x); end
          else if (ncx >= nbx) begin ncx = 0; ex = len_x; end
          if (ncy < 0) begin ncy = nby - 1; ey = -longint'(len_y); end
          else if (ncy >= nby) begin ncy = 0; ey = len_y; end
          j = head[ncx + ncy * 32];
          while (j < N_PART) begin
            if (j != p) begin
              ddx = longint'(pos_x[j]) + ex - pos_x[p];
              ddy = longint'(pos_y[j]) + ey - pos_y[p];
              d2 = ddx * ddx + ddy * ddy;
              if (d2 < longint'({16'd0, radius_sq})) total++;
            end
            j = nxt[j];
          end
        end
      end
      return (total > CNT_MAX) ? CNT_MAX : total;
    endfunction

    function void note_request(bit mode, int idx, int x, int y);
      nbr_result_t r;
      int c;
      r.count  = '0;
      r.status = STATUS_OK;
      if (mode == 1'b0) begin
        if (x >= len_x || y >= len_y) begin
          r.status = STATUS_RANGE;
        end else begin
          c = box_of(x, boxes_in_use(boxes_x)) + box_of(y, boxes_in_use(boxes_y)) * 32;
          pos_x[idx] = x;
          pos_y[idx] = y;
          if (!placed[idx]) begin
            push(idx, c);
            placed[idx] = 1'b1;
            placed_ids.push_back(idx);
          end else if (cell_of[idx] != c) begin
            unlink(idx);
            push(idx, c);
          end
        end
      end else if (!placed[idx]) begin
        r.status = STATUS_UNPLACED;
      end else begin
        r.count = count_near(idx);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [CNT_W-1:0] count, logic [1:0] status);
      nbr_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding: count %0d status %0d", count, status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (count !== e.count) begin
        $error("neighbour_count: expected %0d, actual %0d", e.count, count);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  clnc_in_if  in_if ();
  clnc_out_if out_if ();

  nbr_scoreboard sb = new();

  cell_list_neighbour_count_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // two-phase register write; lands at the rising edge with penable high
  task automatic write_reg(logic [2:0] idx, longint unsigned v);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic set_config(longint unsigned bsz, longint unsigned r2, longint unsigned lx,
                            longint unsigned ly, longint unsigned bx, longint unsigned by);
    write_reg(REG_BOX_SIZE, bsz);
    write_reg(REG_RADIUS_SQ, r2);
    write_reg(REG_LENGTH_X, lx);
    write_reg(REG_LENGTH_Y, ly);
    write_reg(REG_BOXES_X, bx);
    write_reg(REG_BOXES_Y, by);
  endtask

  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  bit src_quiet = 1'b0;

  task automatic send_request(bit mode, int idx, int x, int y);
    int gap;
    if ($urandom_range(0, 19) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.mode = mode;
    in_if.particle_index = IDX_W'(idx);
    in_if.x_position = COORD_W'(x);
    in_if.y_position = COORD_W'(y);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_request(mode, idx, x, y);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic place(int idx, int x, int y);
    send_request(1'b0, idx, x, y);
  endtask

  task automatic query(int idx);
    send_request(1'b1, idx, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
  endtask

  function automatic int coord_in(bit [23:0] len);
    return (len == 0) ? 0 : $urandom_range(0, len - 1);
  endfunction

  task automatic run_random(int n);
    int r;
    int idx;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40 && sb.placed_ids.size() != 0) begin
        query(sb.placed_ids[$urandom_range(0, sb.placed_ids.size() - 1)]);
      end else if (r < 85) begin
        idx = $urandom_range(0, N_PART - 1);
        if ($urandom_range(0, 9) != 0)
          place(idx, coord_in(sb.len_x), coord_in(sb.len_y));
        else
          place(idx, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
      end else if (r < 93) begin
        query($urandom_range(0, N_PART - 1));
      end else begin
        send_request(1'($urandom_range(0, 1)), $urandom_range(0, N_PART - 1),
                     $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
      end
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  int results_seen = 0;
  bit snk_quiet = 1'b0;

  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) snk_quiet = !snk_quiet;
      stall = snk_quiet ? 0 : $urandom_range(0, 10);
      if (results_seen == 60) stall = 400;
      out_if.ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_if.ready = 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      sb.check_result(out_if.neighbour_count, out_if.status);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = 1'b0;
    in_if.particle_index = '0;
    in_if.x_position = '0;
    in_if.y_position = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    set_config(4096, 16777216, 131072, 131072, 32, 32);

    place(0, 0, 0);
    place(1023, 131071, 131071);   // diagonal neighbour across both periodic edges
    query(0);
    query(1023);
    place(5, 131072, 10);
    place(5, 10, 131072);
    place(5, 24'hFFFFFF, 24'hFFFFFF);
    query(5);                      // never placed
    place(1, 4095, 4095);
    place(0, 4000, 100);           // move within the same cell
    place(2, 100, 100);
    place(1, 8192, 0);             // unlink from the middle of a list
    query(0);
    query(1);
    place(2, 9000, 10);            // unlink the list head
    query(1);
    query(2);
    place(512, 65536, 65536);
    query(512);
    run_random(100);

    // degenerate grid: zero cell side, grid sizes outside their range
    wait_idle();
    set_config(0, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 3, 0, 63);
    run_random(100);

    // largest cell side, zero radius: nothing may be counted
    wait_idle();
    set_config(24'hFFFFFF, 0, 50000, 70000, 3, 5);
    run_random(60);

    wait_idle();
    set_config(1000, 2000000, 20000, 20000, 20, 20);
    run_random(140);

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
